/* rtl/rioreg_pkg.sv */
// ----------------------------------------------------------------------------
// rioreg_pkg
// Shared types, register offsets and constants of the I/O FPGA register block.
// ----------------------------------------------------------------------------
package rioreg_pkg;

	// number of network slots with interrupt sources (slot 0 plus modules)
	localparam int unsigned NetSlots = 5;

	localparam int unsigned OffsetWidth = 21;
	localparam int unsigned WordWidth   = 16;
	localparam int unsigned SlotWidth   = 3;
	localparam int unsigned PortWidth   = 4;
	localparam int unsigned CmdWidth    = 3;
	localparam int unsigned CardOfsWidth = 6;
	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned CfgDataWidth  = 4;
	localparam int unsigned InDataWidth  = 80;
	localparam int unsigned OutDataWidth = 32;

	// command codes carried in tuser
	typedef enum logic [CmdWidth-1:0] {
		CMD_READ    = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_IRQ_SET = 3'd2,
		CMD_IRQ_CLR = 3'd3,
		CMD_INSERT  = 3'd4
	} cmd_t;

	// configuration register indexes
	localparam logic [CfgIndexWidth-1:0] CFG_FLASH_PRESENT  = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_MODULE_PRESENT = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_CARD_PRESENT   = 2'd2;

	// register offsets
	localparam logic [OffsetWidth-1:0] OFS_ID0         = 21'h000000;
	localparam logic [OffsetWidth-1:0] OFS_ID1         = 21'h000004;
	localparam logic [OffsetWidth-1:0] OFS_ZERO0       = 21'h00000a;
	localparam logic [OffsetWidth-1:0] OFS_ZERO1       = 21'h00000c;
	localparam logic [OffsetWidth-1:0] OFS_SEEPROM0    = 21'h00000e;
	localparam logic [OffsetWidth-1:0] OFS_FLASH_PRES  = 21'h000012;
	localparam logic [OffsetWidth-1:0] OFS_LOW_BYTE0   = 21'h000014;
	localparam logic [OffsetWidth-1:0] OFS_NET_MAIN    = 21'h000020;
	localparam logic [OffsetWidth-1:0] OFS_NET_SLOTS   = 21'h000022;
	localparam logic [OffsetWidth-1:0] OFS_LOW_BYTE1   = 21'h000026;
	localparam logic [OffsetWidth-1:0] OFS_INSERT_STAT = 21'h000028;
	localparam logic [OffsetWidth-1:0] OFS_SLOT_MASK   = 21'h00002a;
	localparam logic [OffsetWidth-1:0] OFS_IO_MASK_B   = 21'h00002c;
	localparam logic [OffsetWidth-1:0] OFS_SEEPROM1    = 21'h000040;
	localparam logic [OffsetWidth-1:0] OFS_SEEPROM2    = 21'h000042;
	localparam logic [OffsetWidth-1:0] OFS_SEEPROM3    = 21'h000044;
	localparam logic [OffsetWidth-1:0] OFS_SEEPROM4    = 21'h000046;
	localparam logic [OffsetWidth-1:0] OFS_ID2         = 21'h000048;
	localparam logic [OffsetWidth-1:0] OFS_ID3         = 21'h00004a;
	localparam logic [OffsetWidth-1:0] OFS_MODULE_PRES = 21'h00004e;
	localparam logic [OffsetWidth-1:0] OFS_CARD_PRES   = 21'h100004;
	localparam logic [OffsetWidth-1:0] OFS_CARD_TYPE   = 21'h100006;
	localparam logic [OffsetWidth-1:0] OFS_CARD_DATA   = 21'h100008;

	// fixed read values and card select codes
	localparam logic [WordWidth-1:0] ALL_ONES      = 16'hFFFF;
	localparam logic [WordWidth-1:0] LOW_BYTE_ONES = 16'h00FF;
	localparam logic [WordWidth-1:0] CARD_TYPE_VAL = 16'h0004;
	localparam logic [WordWidth-1:0] CARD_SEL0     = 16'h1700;
	localparam logic [WordWidth-1:0] CARD_SEL1     = 16'h1D00;
	localparam logic [WordWidth-1:0] CARD_SEL2     = 16'h3500;
	localparam logic [WordWidth-1:0] MOD1_BIT      = 16'h0100;
	localparam logic [WordWidth-1:0] MOD2_BIT      = 16'h0001;
	localparam logic [WordWidth-1:0] MOD3_BIT      = 16'h1000;
	localparam logic [WordWidth-1:0] MOD4_BIT      = 16'h0010;
	localparam logic [WordWidth-1:0] SYS_FLASH_BIT = 16'h0002;
	localparam logic [WordWidth-1:0] SLOT0_FLASH_BIT = 16'h0001;

	// one input item
	typedef struct packed {
		logic [CmdWidth-1:0]     command;
		logic [OffsetWidth-1:0]  reg_offset;
		logic [WordWidth-1:0]    write_data;
		logic [SlotWidth-1:0]    slot;
		logic [PortWidth-1:0]    port;
		logic [WordWidth-1:0]    insertion_bits;
		logic [WordWidth-1:0]    card_eeprom_word;
	} item_t;

	// one result item
	typedef struct packed {
		logic [WordWidth-1:0]    read_data;
		logic                    net_irq;
		logic                    ext_irq_clear;
		logic                    unknown_access;
		logic                    card_word_used;
		logic [CardOfsWidth-1:0] card_word_offset;
	} result_t;

	// configuration write bundle
	typedef struct packed {
		logic                     wr_en;
		logic [CfgIndexWidth-1:0] index;
		logic [CfgDataWidth-1:0]  data;
	} cfg_wr_t;

endpackage

/* rtl/rioreg_in_stage.sv */
// ----------------------------------------------------------------------------
// rioreg_in_stage
// Input register stage: holds one accepted beat until the core takes it.
// ----------------------------------------------------------------------------
module rioreg_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rioreg_pkg::item_t   in_item,
	output logic                item_valid_s1,
	output rioreg_pkg::item_t   item_s1,
	input  logic                take
);
	import rioreg_pkg::*;

	// stage is free when empty or being drained this cycle
	assign in_ready = !item_valid_s1 || take;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* rtl/rioreg_core.sv */
// ----------------------------------------------------------------------------
// rioreg_core
// Register file, decode and event handling with the result register.
// ----------------------------------------------------------------------------
module rioreg_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rioreg_pkg::cfg_wr_t   cfg,
	input  logic                  item_valid_s1,
	input  rioreg_pkg::item_t     item_s1,
	output logic                  take,
	output logic                  res_valid_q,
	output rioreg_pkg::result_t   res_q,
	input  logic                  res_ready
);
	import rioreg_pkg::*;

	logic [1:0]              flash_present_q;
	logic [3:0]              module_present_q;
	logic [2:0]              card_present_q;
	logic [WordWidth-1:0]    net_main_q, net_slots_q, slot_mask_q, io_mask_b_q;
	logic [WordWidth-1:0]    insert_stat_q, card_sel_q;
	logic                    cmd_word_idx_q, cmd_valid_q;
	logic [CardOfsWidth-1:0] cmd_ofs_q;

	logic [WordWidth-1:0]    net_main_d, net_slots_d, slot_mask_d, io_mask_b_d;
	logic [WordWidth-1:0]    insert_stat_d, card_sel_d;
	logic                    cmd_word_idx_d, cmd_valid_d;
	logic [CardOfsWidth-1:0] cmd_ofs_d;
	result_t                 res_d;

	cmd_t                    cmd;
	logic                    is_rd;
	logic [WordWidth-1:0]    wd;
	logic [WordWidth-1:0]    slot_bit;
	logic [WordWidth-1:0]    main_bit;
	logic                    slot_ok;
	logic                    card_hit;

	// result register frees when empty or drained
	assign take = item_valid_s1 && (!res_valid_q || res_ready);

	assign cmd   = cmd_t'(item_s1.command);
	assign is_rd = (cmd == CMD_READ);
	assign wd    = item_s1.write_data;

	// net event bit positions
	assign main_bit = WordWidth'(1) << item_s1.port;
	assign slot_bit = WordWidth'(1) << {2'(item_s1.slot - 3'd1), item_s1.port[1:0]};
	assign slot_ok  = (32'(item_s1.slot) < NetSlots) && (item_s1.slot <= 3'd4);

	// selected card present
	always_comb begin
		card_hit = 1'b0;
		if (card_sel_q == CARD_SEL0) begin
			card_hit = card_present_q[0];
		end else if (card_sel_q == CARD_SEL1) begin
			card_hit = card_present_q[1];
		end else if (card_sel_q == CARD_SEL2) begin
			card_hit = card_present_q[2];
		end
	end

	// next state and result
	always_comb begin
		net_main_d     = net_main_q;
		net_slots_d    = net_slots_q;
		slot_mask_d    = slot_mask_q;
		io_mask_b_d    = io_mask_b_q;
		insert_stat_d  = insert_stat_q;
		card_sel_d     = card_sel_q;
		cmd_word_idx_d = cmd_word_idx_q;
		cmd_valid_d    = cmd_valid_q;
		cmd_ofs_d      = cmd_ofs_q;
		res_d          = '0;

		case (cmd)
			CMD_READ, CMD_WRITE: begin
				unique case (item_s1.reg_offset) inside
					OFS_ID0, OFS_ID1, OFS_ID2, OFS_ID3: begin
						if (is_rd) res_d.read_data = ALL_ONES;
					end
					OFS_ZERO0, OFS_ZERO1, OFS_SEEPROM0, OFS_SEEPROM1,
					OFS_SEEPROM2, OFS_SEEPROM3, OFS_SEEPROM4: begin
						res_d.read_data = '0;
					end
					OFS_LOW_BYTE0, OFS_LOW_BYTE1: begin
						if (is_rd) res_d.read_data = LOW_BYTE_ONES;
					end
					OFS_FLASH_PRES: begin
						if (is_rd) begin
							res_d.read_data = ALL_ONES
								& ~(flash_present_q[0] ? SYS_FLASH_BIT : '0)
								& ~(flash_present_q[1] ? SLOT0_FLASH_BIT : '0);
						end
					end
					OFS_NET_MAIN: begin
						if (is_rd) res_d.read_data = net_main_q;
					end
					OFS_NET_SLOTS: begin
						if (is_rd) res_d.read_data = net_slots_q;
					end
					OFS_INSERT_STAT: begin
						if (is_rd) begin
							res_d.read_data = insert_stat_q;
						end else begin
							insert_stat_d       = insert_stat_q & ~wd;
							res_d.ext_irq_clear = 1'b1;
						end
					end
					OFS_SLOT_MASK: begin
						if (is_rd) res_d.read_data = slot_mask_q;
						else slot_mask_d = wd;
					end
					OFS_IO_MASK_B: begin
						if (is_rd) res_d.read_data = io_mask_b_q;
						else io_mask_b_d = wd;
					end
					OFS_MODULE_PRES: begin
						if (is_rd) begin
							res_d.read_data = ALL_ONES
								& ~(module_present_q[0] ? MOD1_BIT : '0)
								& ~(module_present_q[1] ? MOD2_BIT : '0)
								& ~(module_present_q[2] ? MOD3_BIT : '0)
								& ~(module_present_q[3] ? MOD4_BIT : '0);
						end
					end
					OFS_CARD_PRES: begin
						if (is_rd) res_d.read_data = ALL_ONES & ~WordWidth'(card_present_q);
						else card_sel_d = wd;
					end
					OFS_CARD_TYPE: begin
						if (is_rd) res_d.read_data = CARD_TYPE_VAL;
					end
					OFS_CARD_DATA: begin
						if (is_rd) begin
							res_d.read_data = ALL_ONES;
							if (cmd_valid_q) begin
								cmd_valid_d = 1'b0;
								if (card_hit) begin
									res_d.read_data        = item_s1.card_eeprom_word;
									res_d.card_word_used   = 1'b1;
									res_d.card_word_offset = cmd_ofs_q;
								end
							end
						end else if (!cmd_word_idx_q) begin
							cmd_ofs_d      = wd[CardOfsWidth-1:0];
							cmd_word_idx_d = 1'b1;
						end else begin
							cmd_word_idx_d = 1'b0;
							cmd_valid_d    = 1'b1;
						end
					end
					default: begin
						res_d.unknown_access = 1'b1;
					end
				endcase
			end
			CMD_IRQ_SET, CMD_IRQ_CLR: begin
				if (!slot_ok) begin
					res_d.unknown_access = 1'b1;
				end else if (item_s1.slot == '0) begin
					net_main_d = (cmd == CMD_IRQ_SET) ? (net_main_q & ~main_bit)
						: (net_main_q | main_bit);
				end else if (item_s1.port[3:2] != 2'b00) begin
					res_d.unknown_access = 1'b1;
				end else begin
					net_slots_d = (cmd == CMD_IRQ_SET) ? (net_slots_q & ~slot_bit)
						: (net_slots_q | slot_bit);
				end
			end
			CMD_INSERT: begin
				insert_stat_d = insert_stat_q | item_s1.insertion_bits;
			end
			default: begin
				res_d.read_data = '0;
			end
		endcase

		// level after this item, active low status words
		res_d.net_irq = (net_main_d != ALL_ONES) || (net_slots_d != ALL_ONES);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_present_q  <= '0;
			module_present_q <= '0;
			card_present_q   <= '0;
		end else if (cfg.wr_en) begin
			unique case (cfg.index)
				CFG_FLASH_PRESENT:  flash_present_q  <= cfg.data[1:0];
				CFG_MODULE_PRESENT: module_present_q <= cfg.data[3:0];
				CFG_CARD_PRESENT:   card_present_q   <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	// block state, updated as each beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_main_q     <= ALL_ONES;
			net_slots_q    <= ALL_ONES;
			slot_mask_q    <= '0;
			io_mask_b_q    <= '0;
			insert_stat_q  <= '0;
			card_sel_q     <= '0;
			cmd_word_idx_q <= 1'b0;
			cmd_valid_q    <= 1'b0;
			cmd_ofs_q      <= '0;
		end else if (take) begin
			net_main_q     <= net_main_d;
			net_slots_q    <= net_slots_d;
			slot_mask_q    <= slot_mask_d;
			io_mask_b_q    <= io_mask_b_d;
			insert_stat_q  <= insert_stat_d;
			card_sel_q     <= card_sel_d;
			cmd_word_idx_q <= cmd_word_idx_d;
			cmd_valid_q    <= cmd_valid_d;
			cmd_ofs_q      <= cmd_ofs_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	// irq level in a fresh result matches the status words
	a_irq_level: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res_q.net_irq == ((net_main_q != ALL_ONES) || (net_slots_q != ALL_ONES)))
		else $error("net_irq does not follow status words");

	// a card data read consumes the captured command
	a_cmd_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_rd && (item_s1.reg_offset == OFS_CARD_DATA)) |=> !cmd_valid_q)
		else $error("card command still valid after data read");

	// a supplied card word only comes with a valid command
	a_card_word: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_d.card_word_used) |-> cmd_valid_q && card_hit)
		else $error("card word used without valid command");

	// clear pulse only from a write beat, never with read data
	a_clear_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.ext_irq_clear) |-> (res_q.read_data == '0) && !res_q.unknown_access)
		else $error("ext_irq_clear with read data or unknown flag");
`endif

endmodule

/* rtl/router_io_fpga_register_block.sv */
// ----------------------------------------------------------------------------
// router_io_fpga_register_block
// Register block of a router I/O FPGA: bus access, network irq and insertion.
// ----------------------------------------------------------------------------
// each input beat passes the input register, then the core's result register
// throughput: one beat per cycle unless stalled; single decode pass in core
// input register and result register are both flow-controlled
// reset: asynchronous, active low; status words go to all ones (inactive)
// masks, insertion status, card select, command capture and presence clear
module router_io_fpga_register_block (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// reg_offset[20:0], write_data[36:21], slot[39:37], port[43:40],
	// insertion_bits[59:44], card_eeprom_word[75:60], zero[79:76]
	input  logic [79:0] s_axis_tdata,
	// command[2:0]
	input  logic [2:0]  s_axis_tuser,
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[15:0], net_irq[16], ext_irq_clear[17], unknown_access[18],
	// card_word_used[19], card_word_offset[25:20], zero[31:26]
	output logic [31:0] m_axis_tdata,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [3:0]  cfg_wdata
);
	import rioreg_pkg::*;

	item_t   in_item, item_s1;
	result_t res_q;
	cfg_wr_t cfg;
	logic    item_valid_s1, take;

	// unpack the input beat
	assign in_item.command          = s_axis_tuser;
	assign in_item.reg_offset       = s_axis_tdata[20:0];
	assign in_item.write_data       = s_axis_tdata[36:21];
	assign in_item.slot             = s_axis_tdata[39:37];
	assign in_item.port             = s_axis_tdata[43:40];
	assign in_item.insertion_bits   = s_axis_tdata[59:44];
	assign in_item.card_eeprom_word = s_axis_tdata[75:60];

	assign cfg.wr_en = cfg_wr_en;
	assign cfg.index = cfg_addr;
	assign cfg.data  = cfg_wdata;

	rioreg_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_item       (in_item),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.take          (take)
	);

	rioreg_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.take          (take),
		.res_valid_q   (m_axis_tvalid),
		.res_q         (res_q),
		.res_ready     (m_axis_tready)
	);

	// pack the result beat
	assign m_axis_tdata = {6'b0, res_q.card_word_offset, res_q.card_word_used,
		res_q.unknown_access, res_q.ext_irq_clear, res_q.net_irq, res_q.read_data};

endmodule
